// ----- rtl/core/lep_pkg.sv -----
// Package for the LED effect PWM controller: mode codes, effect intervals,
// level limits, period reset value and the divide-by-255 constant. No dependencies.
package lep_pkg;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_BLINK  = 3'd2,
    MODE_FBLINK = 3'd3,
    MODE_CYCLE  = 3'd4,
    MODE_FCYCLE = 3'd5,
    MODE_CUSTOM = 3'd6
  } led_mode_t;

  localparam logic [31:0] BLINK_MS  = 32'd550;
  localparam logic [31:0] FBLINK_MS = 32'd175;
  localparam logic [31:0] CYCLE_MS  = 32'd8;
  localparam logic [31:0] FCYCLE_MS = 32'd2;

  localparam logic [7:0]  LEVEL_MAX = 8'd255;
  localparam logic [7:0]  LEVEL_MIN = 8'd0;

  localparam logic [15:0] PERIOD_RESET = 16'd640;

  // ceil(2^32 / 255); exact quotient for every dividend below 2^24
  localparam logic [24:0] RECIP_255 = 25'h1010102;

endpackage

// ----- rtl/core/lep_in_if.sv -----
// Input channel of the LED effect PWM controller: one update call per
// transaction. Depends on nothing.
interface lep_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  led_mode;
  logic [7:0]  custom_level;
  logic [31:0] now_ms;

  modport source (output valid, output led_mode, output custom_level, output now_ms,
                  input ready);
  modport sink   (input valid, input led_mode, input custom_level, input now_ms,
                  output ready);
endinterface

// ----- rtl/core/lep_out_if.sv -----
// Result channel of the LED effect PWM controller: level and PWM compare
// value per transaction. Depends on nothing.
interface lep_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  level_out;
  logic [15:0] compare_value;

  modport source (output valid, output level_out, output compare_value, input ready);
  modport sink   (input valid, input level_out, input compare_value, output ready);
endinterface

// ----- rtl/core/led_effect_pwm_controller.sv -----
// Top level of the LED effect PWM controller (active-low LED).
// Depends on lep_pkg, lep_in_if and lep_out_if.
//
//   channel      dir   handshake        payload
//   in_ch        in    valid/ready      led_mode, custom_level, now_ms
//   out_ch       out   valid/ready      level_out, compare_value
//   period_*     in    write enable     period_wdata (PWM auto-reload)
//
// One transaction per cycle sustained while out_ch is ready; each result is
// registered in stage A, stage B and the output register, then held valid
// on out_ch until out_ch is ready. The rate is set by the effect state update
// (level, ramp direction, last change time), whose loop closes within stage A.
// The duty scaling runs in two multiplier stages behind it.
// Reset is synchronous; there is no clearing pass.
// Each stage holds while the one after it is full and stalled, so input
// transactions keep being accepted into empty stages while a result waits on out_ch.
module led_effect_pwm_controller
  import lep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         period_we,
  input  logic [15:0]  period_wdata,
  lep_in_if.sink       in_ch,
  lep_out_if.source    out_ch
);

  // Configuration register
  logic [15:0] period_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= PERIOD_RESET;
    end else if (period_we) begin
      period_count <= period_wdata;
    end
  end

  // Stage advance chain: a stage may load when empty or when it drains.
  logic a_valid, b_valid, out_valid;
  logic a_adv, b_adv, out_adv, in_fire;

  assign out_adv  = !out_valid || out_ch.ready;
  assign b_adv    = !b_valid || out_adv;
  assign a_adv    = !a_valid || b_adv;
  assign in_ch.ready = a_adv;
  assign in_fire  = in_ch.valid && a_adv;

  // ---------------------------------------------------------------------
  // Stage A: effect state update. Everything that feeds the next
  // transaction lives here so a new update can follow every cycle while stage A can advance.
  // ---------------------------------------------------------------------
  logic [7:0]  current_level, current_level_next;
  logic        ramp_up, ramp_up_next;
  logic [31:0] last_change_time, last_change_time_next;
  logic [31:0] elapsed;
  logic        level_changed;

  assign elapsed = in_ch.now_ms - last_change_time;

  always_comb begin
    current_level_next    = current_level;
    ramp_up_next          = ramp_up;
    last_change_time_next = last_change_time;
    case (led_mode_t'(in_ch.led_mode))
      MODE_OFF: begin
        current_level_next = LEVEL_MAX;
      end
      MODE_ON: begin
        current_level_next = LEVEL_MIN;
      end
      MODE_BLINK, MODE_FBLINK: begin
        if (elapsed > ((in_ch.led_mode == MODE_BLINK) ? BLINK_MS : FBLINK_MS)) begin
          current_level_next    = (current_level == LEVEL_MIN) ? LEVEL_MAX : LEVEL_MIN;
          last_change_time_next = in_ch.now_ms;
        end
      end
      MODE_CYCLE, MODE_FCYCLE: begin
        if (elapsed > ((in_ch.led_mode == MODE_CYCLE) ? CYCLE_MS : FCYCLE_MS)) begin
          // Reverse at either end of the ramp, then step by one.
          if (current_level == LEVEL_MIN) begin
            ramp_up_next = 1'b1;
          end else if (current_level == LEVEL_MAX) begin
            ramp_up_next = 1'b0;
          end
          current_level_next    = ramp_up_next ? current_level + 8'd1
                                               : current_level - 8'd1;
          last_change_time_next = in_ch.now_ms;
        end
      end
      default: begin
        // Custom level; the unused code behaves the same way.
        current_level_next = in_ch.custom_level;
      end
    endcase
  end

  assign level_changed = (current_level_next != current_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level    <= LEVEL_MIN;
      ramp_up          <= 1'b1;
      last_change_time <= '0;
    end else if (in_fire) begin
      current_level    <= current_level_next;
      ramp_up          <= ramp_up_next;
      last_change_time <= last_change_time_next;
    end
  end

  logic [7:0] a_level;
  logic       a_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_level   <= current_level_next;
      a_changed <= level_changed;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: full period x level. User keeps Period stable while items flow; unenforced.
  // ---------------------------------------------------------------------
  logic [16:0] period_full;
  logic [24:0] b_prod;
  logic [7:0]  b_level;
  logic        b_changed;

  assign period_full = {1'b0, period_count} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_prod    <= 25'(period_full) * 25'(a_level);
      b_level   <= a_level;
      b_changed <= a_changed;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: divide by 255 through the reciprocal (the end levels take exact
  // values), then update the held duty compare value only when the level moved.
  // ---------------------------------------------------------------------
  logic [49:0] recip_prod;
  logic [15:0] scaled;
  logic [15:0] duty_compare, duty_compare_next;
  logic [7:0]  level_q;

  assign recip_prod = 50'(b_prod) * 50'(RECIP_255);
  assign scaled     = recip_prod[47:32];

  always_comb begin
    duty_compare_next = duty_compare;
    if (b_changed) begin
      if (b_level == LEVEL_MAX) begin
        duty_compare_next = period_full[15:0];
      end else if (b_level == LEVEL_MIN) begin
        duty_compare_next = '0;
      end else begin
        duty_compare_next = scaled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      duty_compare <= '0;
    end else if (out_adv) begin
      out_valid <= b_valid;
      if (b_valid) begin
        duty_compare <= duty_compare_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && b_valid) begin
      level_q <= b_level;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.level_out     = level_q;
  assign out_ch.compare_value = duty_compare;

`ifndef NO_ASSERTIONS
  // A level of zero always carries a zero compare value.
  a_zero_level_zero_duty: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.level_out == LEVEL_MIN) |-> (out_ch.compare_value == 16'd0))
    else $error("level 0 delivered with nonzero compare value");

  // Mode on forces the LED fully lit (level 0) on the next cycle.
  a_mode_on_level: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.led_mode == MODE_ON) |=> (current_level == LEVEL_MIN))
    else $error("mode on did not force level 0");

  // Mode off forces the LED dark (level 255) on the next cycle.
  a_mode_off_level: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.led_mode == MODE_OFF) |=> (current_level == LEVEL_MAX))
    else $error("mode off did not force level 255");
`endif

endmodule

// ----- dv/tb.sv -----
// Testbench for led_effect_pwm_controller: a directed stimulus table, then random phases,
// mostly under random idling; results checked against typed-in values or the in-bench level/compare predictor.
// Depends on lep_pkg, lep_in_if, lep_out_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lep_pkg::*;

  // Mode code 7 has no package name; the block treats it as custom.
  localparam logic [2:0] MODE_SPARE = 3'd7;

  localparam int DIRECTED_ROWS = 30;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 85;
  localparam int RESET_CYCLES  = 11;
  // Pipeline depth is three; TAIL_CYCLES pads the end of the run on the output side.
  localparam int TAIL_CYCLES   = 12;

  typedef enum logic {ROW_UPDATE, ROW_PERIOD} row_kind_t;

  // One row of the directed table: either an update transaction or a period write.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  mode;
    logic [7:0]  custom;
    logic [31:0] now;
    logic        has_exp;
    logic [7:0]  exp_level;
    logic [15:0] exp_cmp;
    logic [15:0] period;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]  level;
    logic [15:0] cmp;
  } led_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        period_we;
  logic [15:0] period_wdata;

  lep_in_if  in_ch ();
  lep_out_if out_ch ();

  led_effect_pwm_controller dut (
    .clk          (clk),
    .rst          (rst),
    .period_we    (period_we),
    .period_wdata (period_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  // Shadow copy of the block's effect state and period register.
  logic [15:0] model_period;
  logic [7:0]  model_level;
  logic        model_ramp_up;
  logic [31:0] model_last_ms;
  logic [15:0] model_duty;

  // Results still owed by the block, oldest first.
  led_result_t pending_results[$];
  int          errors = 0;
  // Low: no gaps on the input side and no stalls on the output side.
  logic        idle_on = 1'b1;

  // Random generator state: running time base and the current mode streak.
  logic [31:0] phase_clock;
  logic [2:0]  streak_mode;
  int          streak_left;

  // Directed table. Expected values are typed in only where they are obvious;
  // all other update rows are checked against the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Forced levels right after reset, period 640
    '{ROW_UPDATE, MODE_ON,     8'd0,   32'd0,         1'b1, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_OFF,    8'd0,   32'd0,         1'b1, 8'd255, 16'd641,   16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd0,   32'd0,         1'b1, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd255, 32'd0,         1'b1, 8'd255, 16'd641,   16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd128, 32'd0,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_SPARE,  8'd1,   32'd0,         1'b0, 8'd0,   16'd0,     16'd0},
    // Blink thresholds: equal to the interval holds, one past it toggles
    '{ROW_UPDATE, MODE_BLINK,  8'd77,  32'd550,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_BLINK,  8'd77,  32'd551,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_FBLINK, 8'd0,   32'd726,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_FBLINK, 8'd0,   32'd727,       1'b0, 8'd0,   16'd0,     16'd0},
    // Ramp from the top: direction flips to down at 255
    '{ROW_UPDATE, MODE_CYCLE,  8'd0,   32'd735,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_CYCLE,  8'd0,   32'd736,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_FCYCLE, 8'd0,   32'd738,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_FCYCLE, 8'd0,   32'd739,       1'b0, 8'd0,   16'd0,     16'd0},
    // Drop to 0 while ramping down, then ramp with a time base that wraps
    '{ROW_UPDATE, MODE_CUSTOM, 8'd0,   32'd739,       1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_CYCLE,  8'd0,   32'hFFFF_FFFF, 1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_FCYCLE, 8'd0,   32'd2,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_FCYCLE, 8'd0,   32'd4,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_BLINK,  8'd0,   32'hFFFF_FFFF, 1'b0, 8'd0,   16'd0,     16'd0},
    // Period extremes, full-period wrap and a period change with the level held
    '{ROW_PERIOD, MODE_OFF,    8'd0,   32'd0,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd255, 32'd0,         1'b1, 8'd255, 16'd1,     16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd1,   32'd0,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_PERIOD, MODE_OFF,    8'd0,   32'd0,         1'b0, 8'd0,   16'd0,     16'hFFFF},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd255, 32'd0,         1'b1, 8'd255, 16'd0,     16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd254, 32'd0,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_PERIOD, MODE_OFF,    8'd0,   32'd0,         1'b0, 8'd0,   16'd0,     16'd100},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd254, 32'd0,         1'b0, 8'd0,   16'd0,     16'd0},
    '{ROW_UPDATE, MODE_CUSTOM, 8'd0,   32'd0,         1'b1, 8'd0,   16'd0,     16'd0},
    '{ROW_PERIOD, MODE_OFF,    8'd0,   32'd0,         1'b0, 8'd0,   16'd0,     16'hFFFE},
    '{ROW_UPDATE, MODE_OFF,    8'd0,   32'd0,         1'b1, 8'd255, 16'd65535, 16'd0}
  };

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Duty compare for a level under the current period: the ends are exact,
  // everything between is (period + 1) * level / 255, truncated to 16 bits.
  function automatic logic [15:0] scaled_compare(input logic [7:0] lvl);
    logic [31:0] full;
    logic [31:0] quot;
    full = {16'd0, model_period} + 32'd1;
    if (lvl == LEVEL_MAX) return full[15:0];
    if (lvl == LEVEL_MIN) return 16'd0;
    quot = (full * {24'd0, lvl}) / 32'd255;
    return quot[15:0];
  endfunction

  // Recompute the compare value only when the level actually moves.
  function automatic void set_level(input logic [7:0] lvl);
    if (lvl != model_level) begin
      model_duty  = scaled_compare(lvl);
      model_level = lvl;
    end
  endfunction

  // Advance the shadow state by one update call and return what the block owes.
  function automatic led_result_t predict_update(input logic [2:0] mode,
                                                 input logic [7:0] custom,
                                                 input logic [31:0] now);
    logic [31:0] elapsed;
    led_result_t res;
    elapsed = now - model_last_ms;  // wraps modulo 2^32
    case (mode)
      MODE_ON: begin
        set_level(LEVEL_MIN);
        res.level = LEVEL_MIN;
      end
      MODE_OFF: begin
        set_level(LEVEL_MAX);
        res.level = LEVEL_MAX;
      end
      MODE_BLINK, MODE_FBLINK: begin
        if (elapsed > ((mode == MODE_BLINK) ? BLINK_MS : FBLINK_MS)) begin
          set_level((model_level == LEVEL_MIN) ? LEVEL_MAX : LEVEL_MIN);
          model_last_ms = now;
        end
        res.level = model_level;
      end
      MODE_CYCLE, MODE_FCYCLE: begin
        if (elapsed > ((mode == MODE_CYCLE) ? CYCLE_MS : FCYCLE_MS)) begin
          // Reverse at the ends before stepping.
          if (model_level == LEVEL_MIN) model_ramp_up = 1'b1;
          if (model_level == LEVEL_MAX) model_ramp_up = 1'b0;
          set_level(model_ramp_up ? model_level + 8'd1 : model_level - 8'd1);
          model_last_ms = now;
        end
        res.level = model_level;
      end
      default: begin
        // Custom and the spare code pass the given level through.
        set_level(custom);
        res.level = custom;
      end
    endcase
    res.cmp = model_duty;
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    errors++;
  endfunction

  // Gap or stall length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Send one update transaction, then predict it once it is accepted. Valid is
  // dropped only for a gap before it, so back-to-back transactions keep it high.
  task automatic push_update(input logic [2:0] mode, input logic [7:0] custom,
                             input logic [31:0] now, input logic has_exp,
                             input led_result_t typed);
    int gap;
    led_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.led_mode     <= mode;
    in_ch.custom_level <= custom;
    in_ch.now_ms       <= now;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_update(mode, custom, now);
    pending_results.push_back(has_exp ? typed : predicted);
  endtask

  // Hold the input side idle until the block owes nothing.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the period register only with the pipeline empty.
  task automatic write_period(input logic [15:0] value);
    drain_results();
    period_we    <= 1'b1;
    period_wdata <= value;
    @(posedge clk);
    period_we    <= 1'b0;
    model_period = value;
  endtask

  // One random transaction: mostly streaks of one mode with times placed
  // around the effect interval, the rest noise with arbitrary mode and time.
  task automatic push_random_update();
    logic [2:0]  mode;
    logic [7:0]  custom;
    logic [31:0] now;
    logic [31:0] span;
    // Bias custom levels toward the ends so ramps reach both reversals.
    case ($urandom_range(3))
      0:       custom = LEVEL_MIN + 8'($urandom_range(1));
      1:       custom = LEVEL_MAX - 8'($urandom_range(1));
      default: custom = 8'($urandom);
    endcase
    if ($urandom_range(99) < 10) begin
      mode = 3'($urandom_range(7));
      now  = $urandom;
    end else begin
      if (streak_left == 0) begin
        // Favor the ramp modes; they need the most steps to reach their ends.
        if ($urandom_range(2) == 0) streak_mode = $urandom_range(1) ? MODE_CYCLE : MODE_FCYCLE;
        else streak_mode = 3'($urandom_range(7));
        streak_left = $urandom_range(40, 5);
      end
      streak_left--;
      mode = streak_mode;
      case (mode)
        MODE_BLINK:  span = BLINK_MS;
        MODE_FBLINK: span = FBLINK_MS;
        MODE_CYCLE:  span = CYCLE_MS;
        MODE_FCYCLE: span = FCYCLE_MS;
        default:     span = 32'd4;
      endcase
      // Land one below, on, or one past the threshold, or creep forward.
      if ($urandom_range(1)) now = model_last_ms + span + 32'($urandom_range(2)) - 32'd1;
      else now = phase_clock + 32'($urandom_range(span / 2 + 1));
    end
    phase_clock = now;
    push_update(mode, custom, now, 1'b0, '0);
  endtask

  // Output side: accept results with random stalls.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!idle_on) begin
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    led_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, level", 32'd0,
                        {24'd0, out_ch.level_out});
      end else begin
        want = pending_results.pop_front();
        if (out_ch.level_out !== want.level)
          report_mismatch("level_out", {24'd0, want.level}, {24'd0, out_ch.level_out});
        if (out_ch.compare_value !== want.cmp)
          report_mismatch("compare_value", {16'd0, want.cmp}, {16'd0, out_ch.compare_value});
      end
    end
  end

  // Stimulus: reset, directed table, random phases, then drain and decide.
  initial begin
    led_result_t typed;
    in_ch.valid        = 1'b0;
    in_ch.led_mode     = MODE_OFF;
    in_ch.custom_level = 8'd0;
    in_ch.now_ms       = 32'd0;
    period_we          = 1'b0;
    period_wdata       = 16'd0;
    model_period       = PERIOD_RESET;
    model_level        = LEVEL_MIN;
    model_ramp_up      = 1'b1;
    model_last_ms      = 32'd0;
    model_duty         = 16'd0;
    phase_clock        = 32'd0;
    streak_mode        = MODE_CYCLE;
    streak_left        = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_PERIOD) begin
        write_period(directed_rows[i].period);
      end else begin
        typed = {directed_rows[i].exp_level, directed_rows[i].exp_cmp};
        push_update(directed_rows[i].mode, directed_rows[i].custom, directed_rows[i].now,
                    directed_rows[i].has_exp, typed);
      end
    end

    // Each phase starts from an empty pipeline with a fresh period; one phase
    // runs with no gaps or stalls, and some start the time base near its wrap.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       write_period(16'd0);
        1:       write_period(16'hFFFF);
        2:       write_period(16'hFFFE);
        3:       write_period(PERIOD_RESET);
        default: write_period($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15)));
      endcase
      idle_on <= (p != 4);
      phase_clock = (p % 3 == 0) ? 32'hFFFF_FF00 + 32'($urandom_range(255)) : $urandom;
      streak_left = 0;
      repeat (PHASE_ITEMS) push_random_update();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
